[rtl/svi_pkg.sv]
// Shared constants and types of the staggered grid velocity interpolator.
`default_nettype none
package svi_pkg;
    localparam int MAX_COLS_DEF   = 64;
    localparam int MAX_ROWS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int OP_W       = 3;
    localparam int IDX_W      = 7;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 24;
    localparam int INV_W      = 24;
    localparam int SIZE_W     = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;
    localparam int COORD_FRAC = 28;
    localparam int FRAC_W     = 16;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_U  = 3'd0,
        OP_WRITE_V  = 3'd1,
        OP_INTERP_U = 3'd2,
        OP_INTERP_V = 3'd3,
        OP_SNAPSHOT = 3'd4,
        OP_ZERO     = 3'd5
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_W = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_H = 8'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SPLIT,
        ST_WEIGHT,
        ST_READ,
        ST_ROUND,
        ST_SWEEP
    } t_state;
endpackage
`default_nettype wire

[rtl/svi_ifs.sv]
// Request, response and configuration channel interfaces.
`default_nettype none
interface svi_req_if;
    logic                            valid;
    logic                            ready;
    logic [svi_pkg::OP_W-1:0]        op;
    logic [svi_pkg::IDX_W-1:0]       col;
    logic [svi_pkg::IDX_W-1:0]       row;
    logic signed [svi_pkg::DATA_W-1:0] face_value;
    logic [svi_pkg::POS_W-1:0]       pos_x;
    logic [svi_pkg::POS_W-1:0]       pos_y;
    logic                            from_snapshot;
    modport source(output valid, op, col, row, face_value, pos_x, pos_y, from_snapshot,
                   input ready);
    modport sink(input valid, op, col, row, face_value, pos_x, pos_y, from_snapshot,
                 output ready);
endinterface

interface svi_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [svi_pkg::DATA_W-1:0] velocity;
    logic                              saturated;
    modport source(output valid, velocity, saturated, input ready);
    modport sink(input valid, velocity, saturated, output ready);
endinterface

interface svi_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [svi_pkg::CFG_IDX_W-1:0]     index;
    logic [svi_pkg::CFG_DATA_W-1:0]    data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/svi_face_ram.sv]
// Single-port-write, single-port-read face memory with registered read data.
`default_nettype none
module svi_face_ram #(
    parameter int DEPTH = 4225,
    parameter int AW    = 13,
    parameter int DW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/staggered_grid_velocity_interp_core.sv]
// Top level: staggered-grid face store with snapshot, clear and bilinear sampling.
// Usage:
//   i_req carries one request: face writes (ops 0/1), interpolations of u or v
//   (ops 2/3, live or snapshot grid), snapshot copy (op 4) and clear (op 5).
//   o_rsp returns one velocity per interpolation request, saturated, with a flag.
//   i_cfg writes the size and reciprocal cell dimension registers; it is always
//   ready and is to be written only while no request is in flight.
// Operation:
//   A face write goes to memory when it is accepted. An interpolation runs from
//   accept to the result register as one multiply for grid coordinates, one split,
//   one weight product, four reads from the single read port of the selected grid
//   memory (pipelined into multiply and accumulate) and one round.
//   Snapshot and clear sweep the active extent one entry a cycle, since all four
//   grids share one address.
//   One request is worked on at a time; i_req.ready is high only when idle, so
//   a new request is accepted only once the previous one has finished.
// Reset returns the registers to 64 x 64 cells and unit reciprocals; memory
// contents are undefined until written. A stalled o_rsp holds its result, and a
// new request is still accepted; its result waits until the register is free.
`default_nettype none
module staggered_grid_velocity_interp_core #(
    parameter int MAX_COLS   = svi_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS   = svi_pkg::MAX_ROWS_DEF,
    parameter int VALUE_BITS = svi_pkg::VALUE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    svi_req_if.sink    i_req,
    svi_rsp_if.source  o_rsp,
    svi_cfg_if.sink    i_cfg
);
    localparam int DEPTH  = (MAX_COLS + 1) * (MAX_ROWS + 1);
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = AW + 1;
    localparam int NW     = $clog2(MAX_COLS + 2);
    localparam int MW     = $clog2(MAX_ROWS + 2);
    localparam int DW     = svi_pkg::DATA_W;
    localparam int GW     = svi_pkg::POS_W + svi_pkg::INV_W;
    localparam int CELL_W = GW + 1 - svi_pkg::COORD_FRAC;
    localparam int FW     = svi_pkg::FRAC_W;
    localparam int WW     = 2 * FW + 1;
    localparam int PW     = DW + WW + 1;
    localparam int AccW   = PW + 1;
    localparam int QW     = AccW - 32;
    localparam int SB     = (VALUE_BITS < 32) ? VALUE_BITS : 32;

    localparam logic signed [GW:0]     HALF    = (GW+1)'(1) <<< (svi_pkg::COORD_FRAC - 1);
    localparam logic signed [AccW-1:0] ROUND_C = AccW'(1) <<< 31;
    localparam logic signed [QW-1:0]   Q_HI    = (QW'(1) <<< (SB - 1)) - QW'(1);
    localparam logic signed [QW-1:0]   Q_LO    = -Q_HI - QW'(1);
    localparam logic [FW:0]            W_ONE   = (FW+1)'(1) << FW;

    svi_pkg::t_state r_state, n_state;

    logic [svi_pkg::SIZE_W-1:0] r_cols, r_rows;
    logic [svi_pkg::INV_W-1:0]  r_invw, r_invh;

    logic                       r_v, r_snap, r_zero;
    logic [svi_pkg::POS_W-1:0]  r_px, r_py;
    logic [GW-1:0]              r_gx, r_gy;
    logic signed [CELL_W-1:0]   r_ix, r_iy;
    logic [FW-1:0]              r_tx, r_ty;
    logic [WW-1:0]              r_w [4];
    logic [2:0]                 r_step;
    logic                       r_rd_vld, r_rd_ok, r_prod_vld;
    logic [1:0]                 r_rk;
    logic signed [PW-1:0]       r_prod;
    logic signed [AccW-1:0]     r_acc;
    logic [CNT_W-1:0]           r_cnt, r_total, r_ucnt, r_vcnt;
    logic                       r_wpend, r_wu_ok, r_wv_ok;
    logic [AW-1:0]              r_wa;
    logic                       r_out_vld, r_out_sat;
    logic signed [DW-1:0]       r_out_vel;

    // Clamped grid size.
    logic [NW-1:0] n_cols;
    logic [MW-1:0] n_rows;
    always_comb begin
        if (r_cols == '0) begin
            n_cols = NW'(1);
        end else if (int'(r_cols) > MAX_COLS) begin
            n_cols = NW'(MAX_COLS);
        end else begin
            n_cols = NW'(r_cols);
        end
        if (r_rows == '0) begin
            n_rows = MW'(1);
        end else if (int'(r_rows) > MAX_ROWS) begin
            n_rows = MW'(MAX_ROWS);
        end else begin
            n_rows = MW'(r_rows);
        end
    end

    logic [NW-1:0] wu;
    logic [MW-1:0] hv;
    assign wu = n_cols + NW'(1);
    assign hv = n_rows + MW'(1);

    logic accept;
    assign i_req.ready = (r_state == svi_pkg::ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    // Face write decode on the incoming request.
    logic          wr_u, wr_v;
    logic [AW-1:0] wr_addr_u, wr_addr_v;
    always_comb begin
        wr_u = accept && (i_req.op == svi_pkg::OP_WRITE_U)
               && (int'(i_req.col) < int'(wu)) && (int'(i_req.row) < int'(n_rows));
        wr_v = accept && (i_req.op == svi_pkg::OP_WRITE_V)
               && (int'(i_req.col) < int'(n_cols)) && (int'(i_req.row) < int'(hv));
        wr_addr_u = AW'(AW'(i_req.row) * AW'(wu) + AW'(i_req.col));
        wr_addr_v = AW'(AW'(i_req.row) * AW'(n_cols) + AW'(i_req.col));
    end

    // Corner address for the interpolation read sequence.
    logic [NW-1:0]          g_w;
    logic [MW-1:0]          g_h;
    logic signed [CELL_W:0] ii, jj;
    logic                   corner_ok;
    logic [AW-1:0]          corner_addr;
    always_comb begin
        g_w = r_v ? n_cols : wu;
        g_h = r_v ? hv : n_rows;
        ii  = (CELL_W+1)'(r_ix) + (CELL_W+1)'(r_step[0]);
        jj  = (CELL_W+1)'(r_iy) + (CELL_W+1)'(r_step[1]);
        corner_ok = !ii[CELL_W] && !jj[CELL_W]
                    && (ii[CELL_W-1:0] < CELL_W'(g_w))
                    && (jj[CELL_W-1:0] < CELL_W'(g_h));
        corner_addr = AW'(AW'(jj[CELL_W-1:0]) * AW'(g_w) + AW'(ii[CELL_W-1:0]));
    end

    // Memories: one address for all reads, so a sweep copies both grids at once.
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_u, rd_v, rd_us, rd_vs;
    logic          sweep_zero_u, sweep_zero_v;
    assign rd_addr = (r_state == svi_pkg::ST_SWEEP) ? AW'(r_cnt) : corner_addr;
    assign sweep_zero_u = (r_state == svi_pkg::ST_SWEEP) && r_zero && (r_cnt < r_ucnt);
    assign sweep_zero_v = (r_state == svi_pkg::ST_SWEEP) && r_zero && (r_cnt < r_vcnt);

    svi_face_ram #(.DEPTH(DEPTH), .AW(AW), .DW(DW)) u_mem_u (
        .i_clk(i_clk), .i_we(wr_u || sweep_zero_u),
        .i_waddr(sweep_zero_u ? AW'(r_cnt) : wr_addr_u),
        .i_wdata(sweep_zero_u ? '0 : i_req.face_value),
        .i_raddr(rd_addr), .o_rdata(rd_u)
    );
    svi_face_ram #(.DEPTH(DEPTH), .AW(AW), .DW(DW)) u_mem_v (
        .i_clk(i_clk), .i_we(wr_v || sweep_zero_v),
        .i_waddr(sweep_zero_v ? AW'(r_cnt) : wr_addr_v),
        .i_wdata(sweep_zero_v ? '0 : i_req.face_value),
        .i_raddr(rd_addr), .o_rdata(rd_v)
    );
    svi_face_ram #(.DEPTH(DEPTH), .AW(AW), .DW(DW)) u_mem_us (
        .i_clk(i_clk), .i_we(r_wpend && r_wu_ok), .i_waddr(r_wa), .i_wdata(rd_u),
        .i_raddr(rd_addr), .o_rdata(rd_us)
    );
    svi_face_ram #(.DEPTH(DEPTH), .AW(AW), .DW(DW)) u_mem_vs (
        .i_clk(i_clk), .i_we(r_wpend && r_wv_ok), .i_waddr(r_wa), .i_wdata(rd_v),
        .i_raddr(rd_addr), .o_rdata(rd_vs)
    );

    logic signed [DW-1:0] rd_sel;
    always_comb begin
        unique case ({r_v, r_snap})
            2'b00:   rd_sel = $signed(rd_u);
            2'b01:   rd_sel = $signed(rd_us);
            2'b10:   rd_sel = $signed(rd_v);
            default: rd_sel = $signed(rd_vs);
        endcase
        if (!r_rd_ok) begin
            rd_sel = '0;
        end
    end

    // Coordinate split with the half-cell shift on the staggered axis.
    logic signed [GW:0] gsx, gsy;
    assign gsx = $signed({1'b0, r_gx}) - (r_v ? HALF : '0);
    assign gsy = $signed({1'b0, r_gy}) - (r_v ? '0 : HALF);

    logic [FW:0] wx0, wy0;
    assign wx0 = W_ONE - (FW+1)'(r_tx);
    assign wy0 = W_ONE - (FW+1)'(r_ty);

    // Rounding and saturation.
    logic signed [AccW-1:0] qsum;
    logic signed [QW-1:0]   q;
    logic signed [DW-1:0]   q_sat;
    logic                   q_clip;
    always_comb begin
        qsum = r_acc + ROUND_C;
        q    = QW'(qsum >>> 32);
        priority if (q > Q_HI) begin
            q_sat  = DW'(Q_HI);
            q_clip = 1'b1;
        end else if (q < Q_LO) begin
            q_sat  = DW'(Q_LO);
            q_clip = 1'b1;
        end else begin
            q_sat  = DW'(q);
            q_clip = 1'b0;
        end
    end

    logic out_free;
    assign out_free = !r_out_vld || o_rsp.ready;

    logic [CNT_W-1:0] ucnt, vcnt;
    assign ucnt = CNT_W'(CNT_W'(wu) * CNT_W'(n_rows));
    assign vcnt = CNT_W'(CNT_W'(n_cols) * CNT_W'(hv));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            svi_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_req.op == svi_pkg::OP_INTERP_U || i_req.op == svi_pkg::OP_INTERP_V) begin
                        n_state = svi_pkg::ST_MUL;
                    end else if (i_req.op == svi_pkg::OP_SNAPSHOT
                                 || i_req.op == svi_pkg::OP_ZERO) begin
                        n_state = svi_pkg::ST_SWEEP;
                    end
                end
            end
            svi_pkg::ST_MUL:    n_state = svi_pkg::ST_SPLIT;
            svi_pkg::ST_SPLIT:  n_state = svi_pkg::ST_WEIGHT;
            svi_pkg::ST_WEIGHT: n_state = svi_pkg::ST_READ;
            svi_pkg::ST_READ: begin
                if (r_step == 3'd5) begin
                    n_state = svi_pkg::ST_ROUND;
                end
            end
            svi_pkg::ST_ROUND: begin
                if (out_free) begin
                    n_state = svi_pkg::ST_IDLE;
                end
            end
            svi_pkg::ST_SWEEP: begin
                if (r_cnt == r_total) begin
                    n_state = svi_pkg::ST_IDLE;
                end
            end
            default: n_state = svi_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= svi_pkg::ST_IDLE;
            r_cols     <= svi_pkg::SIZE_W'(64);
            r_rows     <= svi_pkg::SIZE_W'(64);
            r_invw     <= svi_pkg::INV_W'(65536);
            r_invh     <= svi_pkg::INV_W'(65536);
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
            r_wpend    <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    svi_pkg::CFG_COLS:  r_cols <= i_cfg.data[svi_pkg::SIZE_W-1:0];
                    svi_pkg::CFG_ROWS:  r_rows <= i_cfg.data[svi_pkg::SIZE_W-1:0];
                    svi_pkg::CFG_INV_W: r_invw <= i_cfg.data;
                    svi_pkg::CFG_INV_H: r_invh <= i_cfg.data;
                    default: ;
                endcase
            end
            r_rd_vld   <= (r_state == svi_pkg::ST_READ) && !r_step[2];
            r_prod_vld <= r_rd_vld;
            r_wpend    <= (r_state == svi_pkg::ST_SWEEP) && !r_zero && (r_cnt < r_total);
            if (r_state == svi_pkg::ST_ROUND && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_v     <= (i_req.op == svi_pkg::OP_INTERP_V);
            r_snap  <= i_req.from_snapshot;
            r_zero  <= (i_req.op == svi_pkg::OP_ZERO);
            r_px    <= i_req.pos_x;
            r_py    <= i_req.pos_y;
            r_cnt   <= '0;
            r_ucnt  <= ucnt;
            r_vcnt  <= vcnt;
            r_total <= (ucnt > vcnt) ? ucnt : vcnt;
        end
        if (r_state == svi_pkg::ST_MUL) begin
            r_gx <= GW'(r_px) * GW'(r_invw);
            r_gy <= GW'(r_py) * GW'(r_invh);
        end
        if (r_state == svi_pkg::ST_SPLIT) begin
            r_ix <= CELL_W'(gsx >>> svi_pkg::COORD_FRAC);
            r_iy <= CELL_W'(gsy >>> svi_pkg::COORD_FRAC);
            r_tx <= gsx[svi_pkg::COORD_FRAC-1 -: FW];
            r_ty <= gsy[svi_pkg::COORD_FRAC-1 -: FW];
        end
        if (r_state == svi_pkg::ST_WEIGHT) begin
            r_w[0] <= WW'(wx0) * WW'(wy0);
            r_w[1] <= WW'(r_tx) * WW'(wy0);
            r_w[2] <= WW'(wx0) * WW'(r_ty);
            r_w[3] <= WW'(r_tx) * WW'(r_ty);
            r_acc  <= '0;
            r_step <= '0;
        end
        if (r_state == svi_pkg::ST_READ) begin
            r_step <= r_step + 3'd1;
            r_rd_ok <= corner_ok;
            r_rk    <= r_step[1:0];
        end
        if (r_rd_vld) begin
            r_prod <= rd_sel * $signed({1'b0, r_w[r_rk]});
        end
        if (r_prod_vld) begin
            r_acc <= r_acc + r_prod;
        end
        if (r_state == svi_pkg::ST_ROUND && out_free) begin
            r_out_vel <= q_sat;
            r_out_sat <= q_clip;
        end
        if (r_state == svi_pkg::ST_SWEEP) begin
            r_cnt   <= r_cnt + CNT_W'(1);
            r_wa    <= AW'(r_cnt);
            r_wu_ok <= r_cnt < r_ucnt;
            r_wv_ok <= r_cnt < r_vcnt;
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.velocity  = r_out_vel;
    assign o_rsp.saturated = r_out_sat;
endmodule
`default_nettype wire
